// File: design/vfc_pkg.sv
`timescale 1ns / 1ps

package vfc_pkg;

	localparam int MODE_W     = 2;
	localparam int IDX_W      = 14;
	localparam int ID_W       = 8;
	localparam int POS_X_W    = 4;
	localparam int POS_Y_W    = 6;
	localparam int POS_Z_W    = 4;
	localparam int SIDE_W     = 3;
	localparam int FACE_NUM_W = 17;
	localparam int NUM_SIDES  = 6;

	localparam int CHUNK_W_DEF = 16;
	localparam int CHUNK_H_DEF = 64;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MESH  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [SIDE_W-1:0] SIDE_FRONT  = 3'd0;
	localparam logic [SIDE_W-1:0] SIDE_BACK   = 3'd1;
	localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd2;
	localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd3;
	localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd4;
	localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd5;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_MESH,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [IDX_W-1:0] idx;
		logic [ID_W-1:0]  id;
	} cmd_t;

endpackage

// File: design/vfc_in_if.sv
`timescale 1ns / 1ps

interface vfc_in_if import vfc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [IDX_W-1:0]  cell_index;
	logic [ID_W-1:0]   block_id;

	modport source (output valid, mode, cell_index, block_id, input ready);
	modport sink (input valid, mode, cell_index, block_id, output ready);
endinterface

// File: design/vfc_out_if.sv
`timescale 1ns / 1ps

interface vfc_out_if import vfc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [POS_X_W-1:0]    pos_x;
	logic [POS_Y_W-1:0]    pos_y;
	logic [POS_Z_W-1:0]    pos_z;
	logic [SIDE_W-1:0]     face_side;
	logic [FACE_NUM_W-1:0] face_number;
	logic                  last;

	modport source (output valid, pos_x, pos_y, pos_z, face_side, face_number, last,
		input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, face_side, face_number, last,
		output ready);
endinterface

// File: design/voxel_face_culler_unit.sv
`timescale 1ns / 1ps
// A meshed cell passes the front register and the queue; the back end reads the cell, ends
// the mesh there if it is empty, else splits its index, reads the six neighbors and emits
// its visible faces. Throughput is set by the single-port block store in the back end.
// The front stage and 4-entry queue keep taking transactions while the back end works.
// Reset (arst_n, async low) clears control and the face counter; store contents undefined.

module voxel_face_culler_unit import vfc_pkg::*; #(
	parameter int CHUNK_W = CHUNK_W_DEF,
	parameter int CHUNK_H = CHUNK_H_DEF
) (
	input  logic clk,
	input  logic arst_n,
	vfc_in_if.sink cmd,
	vfc_out_if.source face
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	vfc_front #(
		.CHUNK_W(CHUNK_W),
		.CHUNK_H(CHUNK_H)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	vfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	vfc_back #(
		.CHUNK_W(CHUNK_W),
		.CHUNK_H(CHUNK_H)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_cmd  (pop_cmd),
		.face     (face)
	);

endmodule

// File: design/vfc_front.sv
`timescale 1ns / 1ps

module vfc_front import vfc_pkg::*; #(
	parameter int CHUNK_W = CHUNK_W_DEF,
	parameter int CHUNK_H = CHUNK_H_DEF
) (
	input  logic clk,
	input  logic arst_n,
	vfc_in_if.sink cmd,
	output logic push_valid,
	input  logic push_ready,
	output cmd_t push_cmd
);

	localparam int VOLUME    = CHUNK_W * CHUNK_W * CHUNK_H;
	localparam int MEM_DEPTH = (VOLUME < (1 << IDX_W)) ? VOLUME : (1 << IDX_W);

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;
	logic in_range;
	logic keep;
	op_t  op;

	assign cmd.ready  = !valid_s1 || push_ready;
	assign accept     = cmd.valid && cmd.ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	assign in_range = (IDX_W + 1)'(cmd.cell_index) < (IDX_W + 1)'(MEM_DEPTH);

	// out-of-chunk writes and meshes, and the unused mode, are dropped here
	always_comb begin
		keep = 1'b0;
		op   = OP_CLEAR;
		case (cmd.mode)
			MODE_WRITE: begin
				keep = in_range;
				op   = OP_WRITE;
			end
			MODE_MESH: begin
				keep = in_range;
				op   = OP_MESH;
			end
			MODE_CLEAR: begin
				keep = 1'b1;
				op   = OP_CLEAR;
			end
			default: begin
				keep = 1'b0;
				op   = OP_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op  <= op;
			cmd_s1.idx <= cmd.cell_index;
			cmd_s1.id  <= cmd.block_id;
		end
	end

endmodule

// File: design/vfc_queue.sv
`timescale 1ns / 1ps

module vfc_queue import vfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t            entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != (Q_AW + 1)'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: design/vfc_back.sv
`timescale 1ns / 1ps

module vfc_back import vfc_pkg::*; #(
	parameter int CHUNK_W = CHUNK_W_DEF,
	parameter int CHUNK_H = CHUNK_H_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  cmd_t pop_cmd,
	vfc_out_if.source face
);

	localparam int VOLUME    = CHUNK_W * CHUNK_W * CHUNK_H;
	localparam int MEM_DEPTH = (VOLUME < (1 << IDX_W)) ? VOLUME : (1 << IDX_W);
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int XW        = $clog2(CHUNK_W);
	localparam int YW        = $clog2(CHUNK_H);
	localparam int NW        = IDX_W + 1;
	// divide by CHUNK_W as multiply by reciprocal; exact for IDX_W-bit operands
	localparam int DIV_S     = IDX_W + XW;
	localparam int MW        = IDX_W + 1;
	localparam int PW        = IDX_W + MW;
	localparam logic [MW-1:0] DIV_M = MW'((1 << DIV_S) / CHUNK_W + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV1,
		S_DIV2,
		S_DIV3,
		S_NBR,
		S_NBR_END,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      q1_q;
	logic [XW-1:0]         x_q;
	logic [YW-1:0]         y_q;
	logic [XW-1:0]         z_q;
	logic [SIDE_W-1:0]     side_q;
	logic [NUM_SIDES-1:0]  vis_q;
	logic [FACE_NUM_W-1:0] face_cnt_q;
	logic                  chk_s1;
	logic [SIDE_W-1:0]     side_s1;
	logic                  edge_s1;

	logic                  out_valid_q;
	logic [POS_X_W-1:0]    pos_x_q;
	logic [POS_Y_W-1:0]    pos_y_q;
	logic [POS_Z_W-1:0]    pos_z_q;
	logic [SIDE_W-1:0]     face_side_q;
	logic [FACE_NUM_W-1:0] face_number_q;
	logic                  last_q;

	logic [ID_W-1:0]       block_store_q [MEM_DEPTH];
	logic [ID_W-1:0]       rdata_q;
	logic                  mem_we;
	logic [MEM_AW-1:0]     mem_addr;

	logic [PW-1:0]         prod1;
	logic [PW-1:0]         prod2;
	logic [NW-1:0]         nbr_addr;
	logic                  nbr_edge;
	logic                  nbr_oob;
	logic [SIDE_W-1:0]     sel_side;
	logic [NUM_SIDES-1:0]  remain;
	logic                  emit;
	logic                  emit_last;

	assign pop_ready = state_q == S_IDLE;

	assign prod1 = PW'(idx_q) * PW'(DIV_M);
	assign prod2 = PW'(q1_q) * PW'(DIV_M);

	always_comb begin
		nbr_addr = NW'(idx_q);
		nbr_edge = 1'b1;
		case (side_q)
			SIDE_FRONT: begin
				nbr_addr = NW'(idx_q) + NW'(CHUNK_W);
				nbr_edge = z_q == XW'(CHUNK_W - 1);
			end
			SIDE_BACK: begin
				nbr_addr = NW'(idx_q) - NW'(CHUNK_W);
				nbr_edge = z_q == '0;
			end
			SIDE_RIGHT: begin
				nbr_addr = NW'(idx_q) + NW'(1);
				nbr_edge = x_q == XW'(CHUNK_W - 1);
			end
			SIDE_LEFT: begin
				nbr_addr = NW'(idx_q) - NW'(1);
				nbr_edge = x_q == '0;
			end
			SIDE_TOP: begin
				nbr_addr = NW'(idx_q) + NW'(CHUNK_W * CHUNK_W);
				nbr_edge = y_q == YW'(CHUNK_H - 1);
			end
			SIDE_BOTTOM: begin
				nbr_addr = NW'(idx_q) - NW'(CHUNK_W * CHUNK_W);
				nbr_edge = y_q == '0;
			end
			default: begin
				nbr_addr = NW'(idx_q);
				nbr_edge = 1'b1;
			end
		endcase
	end

	// cells past the addressable range are never written, so they read as empty
	assign nbr_oob = nbr_addr >= NW'(MEM_DEPTH);

	assign mem_we   = (state_q == S_IDLE) && pop_valid && (pop_cmd.op == OP_WRITE);
	assign mem_addr = (state_q == S_NBR) ? MEM_AW'(nbr_addr) : MEM_AW'(pop_cmd.idx);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			block_store_q[mem_addr] <= pop_cmd.id;
		end
		rdata_q <= block_store_q[mem_addr];
	end

	always_comb begin
		sel_side = '0;
		for (int i = NUM_SIDES - 1; i >= 0; i--) begin
			if (vis_q[i]) begin
				sel_side = SIDE_W'(i);
			end
		end
	end

	assign remain    = vis_q & ~(NUM_SIDES'(1) << sel_side);
	assign emit      = (state_q == S_EMIT) && (vis_q != '0) && (!out_valid_q || face.ready);
	assign emit_last = remain == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			idx_q         <= '0;
			q1_q          <= '0;
			x_q           <= '0;
			y_q           <= '0;
			z_q           <= '0;
			side_q        <= '0;
			vis_q         <= '0;
			face_cnt_q    <= '0;
			chk_s1        <= 1'b0;
			side_s1       <= '0;
			edge_s1       <= 1'b0;
			out_valid_q   <= 1'b0;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			pos_z_q       <= '0;
			face_side_q   <= '0;
			face_number_q <= '0;
			last_q        <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (face.ready) begin
				out_valid_q <= 1'b0;
			end
			chk_s1 <= state_q == S_NBR;
			if (chk_s1) begin
				vis_q[side_s1] <= edge_s1 || (rdata_q == '0);
			end

			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						case (pop_cmd.op)
							OP_MESH: begin
								idx_q   <= pop_cmd.idx;
								state_q <= S_DIV1;
							end
							OP_CLEAR: begin
								face_cnt_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV1: begin
					q1_q <= IDX_W'(prod1 >> DIV_S);
					// center cell is in rdata_q now; an empty cell has no faces
					state_q <= (rdata_q == '0) ? S_IDLE : S_DIV2;
				end
				S_DIV2: begin
					x_q     <= XW'(idx_q - IDX_W'(q1_q * IDX_W'(CHUNK_W)));
					y_q     <= YW'(prod2 >> DIV_S);
					state_q <= S_DIV3;
				end
				S_DIV3: begin
					z_q     <= XW'(q1_q - IDX_W'(IDX_W'(y_q) * IDX_W'(CHUNK_W)));
					side_q  <= SIDE_FRONT;
					vis_q   <= '0;
					state_q <= S_NBR;
				end
				S_NBR: begin
					side_s1 <= side_q;
					edge_s1 <= nbr_edge || nbr_oob;
					if (side_q == SIDE_BOTTOM) begin
						state_q <= S_NBR_END;
					end else begin
						side_q <= side_q + 1'b1;
					end
				end
				S_NBR_END: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (vis_q == '0) begin
						state_q <= S_IDLE;
					end else if (emit) begin
						pos_x_q       <= POS_X_W'(x_q);
						pos_y_q       <= POS_Y_W'(y_q);
						pos_z_q       <= POS_Z_W'(z_q);
						face_side_q   <= sel_side;
						face_number_q <= face_cnt_q;
						last_q        <= emit_last;
						face_cnt_q    <= face_cnt_q + 1'b1;
						vis_q         <= remain;
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign face.valid       = out_valid_q;
	assign face.pos_x       = pos_x_q;
	assign face.pos_y       = pos_y_q;
	assign face.pos_z       = pos_z_q;
	assign face.face_side   = face_side_q;
	assign face.face_number = face_number_q;
	assign face.last        = last_q;

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> face_cnt_q == FACE_NUM_W'($past(face_cnt_q) + 1'b1))
		else $error("face counter did not advance by one on a face transaction");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> state_q == S_IDLE && vis_q == '0)
		else $error("faces left after the last face of a cell");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("face output loaded outside the emit state");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !mem_we)
		else $error("store written while a cell is being meshed");

endmodule

// File: verif/tb_voxel_face_culler_unit.sv
`timescale 1ns / 1ps

module tb_voxel_face_culler_unit;
	import vfc_pkg::*;

	localparam int CW           = CHUNK_W_DEF;
	localparam int CH           = CHUNK_H_DEF;
	localparam int LAYER_SZ     = CW * CW;
	localparam int CELLS        = LAYER_SZ * CH;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int CYCLE_LIMIT  = 100_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 256;
	localparam int DRAIN_CYCLES = 40;
	localparam int DIR_ROWS     = 24;

	typedef struct packed {
		logic [POS_X_W-1:0]    pos_x;
		logic [POS_Y_W-1:0]    pos_y;
		logic [POS_Z_W-1:0]    pos_z;
		logic [SIDE_W-1:0]     side;
		logic [FACE_NUM_W-1:0] num;
		logic                  last;
	} face_rec_t;

	typedef struct {
		logic [MODE_W-1:0]    mode;
		int                   idx;
		logic [ID_W-1:0]      id;
		bit                   typed;
		bit [NUM_SIDES-1:0]   shown;
		int                   first_num;
	} dir_row_t;

	logic clk;
	logic arst_n;

	vfc_in_if  cmd_if ();
	vfc_out_if face_if ();

	voxel_face_culler_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.face   (face_if)
	);

	bit [ID_W-1:0]         chunk_ids [CELLS];
	bit                    written [CELLS];
	bit [FACE_NUM_W-1:0]   face_count;
	face_rec_t             new_faces [NUM_SIDES];
	face_rec_t             face_q [$];

	int errors;
	int cycle_count;
	int n_items;
	int n_meshes;
	int n_faces;
	bit idle_on;
	bit hold_req;
	bit hold_done;

	// typed rows: shown = visible side mask, first_num = first face number
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{MODE_WRITE, 0,     8'd255, 1'b0, 6'b000000, 0},
		'{MODE_WRITE, 1,     8'd0,   1'b0, 6'b000000, 0},
		'{MODE_WRITE, 16,    8'd0,   1'b0, 6'b000000, 0},
		'{MODE_WRITE, 256,   8'd0,   1'b0, 6'b000000, 0},
		'{MODE_MESH,  0,     8'd0,   1'b1, 6'b111111, 0},
		'{MODE_CLEAR, 0,     8'd0,   1'b1, 6'b000000, 0},
		'{MODE_WRITE, 1,     8'd1,   1'b0, 6'b000000, 0},
		'{MODE_MESH,  0,     8'd255, 1'b1, 6'b111011, 0},
		'{MODE_WRITE, 16383, 8'd128, 1'b0, 6'b000000, 0},
		'{MODE_WRITE, 16367, 8'd7,   1'b0, 6'b000000, 0},
		'{MODE_WRITE, 16382, 8'd0,   1'b0, 6'b000000, 0},
		'{MODE_WRITE, 16127, 8'd0,   1'b0, 6'b000000, 0},
		'{MODE_MESH,  16383, 8'd0,   1'b1, 6'b111101, 5},
		'{MODE_SPARE, 16383, 8'd255, 1'b1, 6'b000000, 0},
		'{MODE_WRITE, 16383, 8'd0,   1'b0, 6'b000000, 0},
		'{MODE_MESH,  16383, 8'd0,   1'b1, 6'b000000, 0},
		'{MODE_WRITE, 273,   8'd42,  1'b0, 6'b000000, 0},
		'{MODE_WRITE, 289,   8'd1,   1'b0, 6'b000000, 0},
		'{MODE_WRITE, 257,   8'd2,   1'b0, 6'b000000, 0},
		'{MODE_WRITE, 274,   8'd3,   1'b0, 6'b000000, 0},
		'{MODE_WRITE, 272,   8'd4,   1'b0, 6'b000000, 0},
		'{MODE_WRITE, 529,   8'd5,   1'b0, 6'b000000, 0},
		'{MODE_WRITE, 17,    8'd6,   1'b0, 6'b000000, 0},
		'{MODE_MESH,  273,   8'd0,   1'b1, 6'b000000, 0}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d faces still expected", cycle_count, face_q.size());
		$display("FAILURE");
		$finish;
	end

	function automatic bit side_open(int idx, logic [SIDE_W-1:0] s);
		int x, y, z;
		x = idx % CW;
		z = (idx / CW) % CW;
		y = idx / LAYER_SZ;
		case (s)
			SIDE_FRONT: return z == CW - 1 || chunk_ids[idx + CW] == 0;
			SIDE_BACK:  return z == 0 || chunk_ids[idx - CW] == 0;
			SIDE_RIGHT: return x == CW - 1 || chunk_ids[idx + 1] == 0;
			SIDE_LEFT:  return x == 0 || chunk_ids[idx - 1] == 0;
			SIDE_TOP:   return y == CH - 1 || chunk_ids[idx + LAYER_SZ] == 0;
			default:    return y == 0 || chunk_ids[idx - LAYER_SZ] == 0;
		endcase
	endfunction

	// fills new_faces with one record per visible side, in side order
	function automatic int expand_faces(int idx, bit [NUM_SIDES-1:0] shown,
			bit [FACE_NUM_W-1:0] first_num);
		int n;
		bit [FACE_NUM_W-1:0] num;
		n = 0;
		num = first_num;
		for (int s = 0; s < NUM_SIDES; s++) begin
			if (shown[s]) begin
				new_faces[n].pos_x = POS_X_W'(idx % CW);
				new_faces[n].pos_y = POS_Y_W'(idx / LAYER_SZ);
				new_faces[n].pos_z = POS_Z_W'((idx / CW) % CW);
				new_faces[n].side  = SIDE_W'(s);
				new_faces[n].num   = num;
				new_faces[n].last  = (shown >> (s + 1)) == 0;
				num++;
				n++;
			end
		end
		return n;
	endfunction

	function automatic int mesh_predict(logic [MODE_W-1:0] mode, int idx,
			logic [ID_W-1:0] id);
		bit [NUM_SIDES-1:0] shown;
		int n;
		n = 0;
		if (mode == MODE_WRITE) begin
			chunk_ids[idx] = id;
			written[idx] = 1'b1;
		end else if (mode == MODE_CLEAR) begin
			face_count = '0;
		end else if (mode == MODE_MESH && chunk_ids[idx] != 0) begin
			for (int s = 0; s < NUM_SIDES; s++)
				shown[s] = side_open(idx, s[SIDE_W-1:0]);
			n = expand_faces(idx, shown, face_count);
			face_count = face_count + n[FACE_NUM_W-1:0];
		end
		return n;
	endfunction

	task automatic send_cmd(logic [MODE_W-1:0] mode, int idx, logic [ID_W-1:0] id,
			bit typed = 1'b0, bit [NUM_SIDES-1:0] shown = '0, int first_num = 0);
		int gap;
		int n;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_if.valid      <= 1'b1;
		cmd_if.mode       <= mode;
		cmd_if.cell_index <= idx[IDX_W-1:0];
		cmd_if.block_id   <= id;
		do @(posedge clk); while (!cmd_if.ready);
		n = mesh_predict(mode, idx, id);
		if (typed)
			n = expand_faces(idx, shown, first_num[FACE_NUM_W-1:0]);
		for (int k = 0; k < n; k++)
			face_q.push_back(new_faces[k]);
		n_items++;
		if (mode == MODE_MESH)
			n_meshes++;
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return '0;
		else if (r == 9)
			return '1;
		return ID_W'($urandom_range(1, 254));
	endfunction

	// cells near the chunk corners, so neighbors get reused and every index bit toggles
	function automatic int focus_cell();
		int x, y, z;
		x = $urandom_range(0, 7);
		z = $urandom_range(0, 7);
		y = $urandom_range(0, 7);
		if (x > 3) x += CW - 8;
		if (z > 3) z += CW - 8;
		if (y > 3) y += CH - 8;
		return x + z * CW + y * LAYER_SZ;
	endfunction

	// the block reads the cell and its in-chunk neighbors, so all must hold data
	task automatic prep_cell(int idx);
		int x, y, z;
		x = idx % CW;
		z = (idx / CW) % CW;
		y = idx / LAYER_SZ;
		if (!written[idx]) send_cmd(MODE_WRITE, idx, ID_W'($urandom_range(1, 255)));
		if (z < CW - 1 && !written[idx + CW]) send_cmd(MODE_WRITE, idx + CW, pick_id());
		if (z > 0 && !written[idx - CW]) send_cmd(MODE_WRITE, idx - CW, pick_id());
		if (x < CW - 1 && !written[idx + 1]) send_cmd(MODE_WRITE, idx + 1, pick_id());
		if (x > 0 && !written[idx - 1]) send_cmd(MODE_WRITE, idx - 1, pick_id());
		if (y < CH - 1 && !written[idx + LAYER_SZ])
			send_cmd(MODE_WRITE, idx + LAYER_SZ, pick_id());
		if (y > 0 && !written[idx - LAYER_SZ])
			send_cmd(MODE_WRITE, idx - LAYER_SZ, pick_id());
	endtask

	initial begin : face_sink
		int stall;
		face_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				face_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = idle_on ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				face_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			face_if.ready <= 1'b1;
			do @(posedge clk); while (!face_if.valid);
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : face_check
		face_rec_t want;
		if (arst_n && face_if.valid && face_if.ready) begin
			if (face_q.size() == 0) begin
				errors++;
				$display("%0t ns: face with none expected, actual x=%0d y=%0d z=%0d side=%0d num=%0d",
					$time, face_if.pos_x, face_if.pos_y, face_if.pos_z, face_if.face_side,
					face_if.face_number);
			end else begin
				want = face_q.pop_front();
				check_field("pos_x", 32'(want.pos_x), 32'(face_if.pos_x));
				check_field("pos_y", 32'(want.pos_y), 32'(face_if.pos_y));
				check_field("pos_z", 32'(want.pos_z), 32'(face_if.pos_z));
				check_field("face_side", 32'(want.side), 32'(face_if.face_side));
				check_field("face_number", 32'(want.num), 32'(face_if.face_number));
				check_field("last", 32'(want.last), 32'(face_if.last));
				n_faces++;
			end
		end
	end

	initial begin : stimulus
		int r;
		int idx;
		int rand_start;
		arst_n            = 1'b0;
		cmd_if.valid      = 1'b0;
		cmd_if.mode       = MODE_WRITE;
		cmd_if.cell_index = '0;
		cmd_if.block_id   = '0;
		idle_on           = 1'b1;
		hold_req          = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_cmd(dir_tab[i].mode, dir_tab[i].idx, dir_tab[i].id, dir_tab[i].typed,
				dir_tab[i].shown, dir_tab[i].first_num);

		rand_start = n_items;
		while (n_items - rand_start < RANDOM_ITEMS) begin
			// every third stretch of 60 transactions runs without gaps on either side
			idle_on = ((n_items - rand_start) / 60) % 3 != 2;
			if (n_items - rand_start >= 20)
				hold_req = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 50) begin
				idx = focus_cell();
				prep_cell(idx);
				send_cmd(MODE_MESH, idx, ID_W'($urandom));
			end else if (r < 78) begin
				send_cmd(MODE_WRITE, focus_cell(), pick_id());
			end else if (r < 86) begin
				send_cmd(MODE_WRITE, $urandom_range(0, CELLS - 1), ID_W'($urandom));
			end else if (r < 93) begin
				send_cmd(MODE_CLEAR, $urandom_range(0, CELLS - 1), ID_W'($urandom));
			end else begin
				send_cmd(MODE_SPARE, $urandom_range(0, CELLS - 1), ID_W'($urandom));
			end
		end

		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (face_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions (%0d meshes) and checked %0d faces.",
			n_items, n_meshes, n_faces);
		$display("Covered chunk corners, hidden and empty cells, the spare mode and a long output stall.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
